>>> hw/rtl/sfc_pkg.sv
package sfc_pkg;

  localparam int unsigned LenW     = 14;
  localparam int unsigned OffW     = 6;
  localparam int unsigned OutDataW = 40;

  localparam logic [LenW-1:0] MaxLenReset = 14'd1518;
  localparam logic [LenW-1:0] FieldMax    = 14'h3FFF;

  localparam logic [OffW-1:0] UdpOffset = 6'd42;
  localparam logic [OffW-1:0] TcpOffset = 6'd54;

  localparam logic [15:0] EtherTypeIpv4 = 16'h0800;
  localparam logic [7:0]  ProtoTcp      = 8'd6;
  localparam logic [7:0]  ProtoUdp      = 8'd17;
  localparam logic [31:0] SipWord       = 32'h5349_502F;
  localparam logic [7:0]  CharNewline   = 8'h0A;
  localparam logic [7:0]  CharS         = 8'h53;

  localparam int unsigned PosEtherHi  = 12;
  localparam int unsigned PosEtherLo  = 13;
  localparam int unsigned PosVersion  = 14;
  localparam int unsigned PosProtocol = 23;
  localparam int unsigned EtherHdrLen = 14;
  localparam int unsigned ProtoEnd    = 24;
  localparam int unsigned PrefixLen   = 4;
  localparam int unsigned MarkerGap   = 7;

  typedef enum logic [2:0] {
    VERDICT_SIP          = 3'd0,
    VERDICT_TOO_LONG     = 3'd1,
    VERDICT_NOT_ETHERIP  = 3'd2,
    VERDICT_NOT_IPV4     = 3'd3,
    VERDICT_NOT_TCP_UDP  = 3'd4,
    VERDICT_NO_SIP       = 3'd5
  } verdict_e;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_UDP   = 2'd1,
    KIND_TCP   = 2'd2,
    KIND_OTHER = 2'd3
  } kind_e;

  typedef struct packed {
    logic [LenW-1:0] frame_length;
    logic [LenW-1:0] sip_length;
    logic [OffW-1:0] sip_offset;
    logic            is_response;
    verdict_e        verdict;
  } sfc_result_t;

  function automatic logic [OffW-1:0] payload_off(kind_e kind);
    logic [OffW-1:0] off;
    unique case (kind)
      KIND_UDP: off = UdpOffset;
      KIND_TCP: off = TcpOffset;
      default:  off = '0;
    endcase
    return off;
  endfunction

  // expected byte of "IP/" after the last S
  function automatic logic [7:0] ip_tail(logic [1:0] idx);
    logic [7:0] ch;
    unique case (idx)
      2'd0:    ch = 8'h49;
      2'd1:    ch = 8'h50;
      2'd2:    ch = 8'h2F;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

>>> hw/rtl/sip_frame_classifier.sv
// sip frame classifier
// input stream: one frame byte per item, tlast on the final byte of the frame.
// output stream: one verdict item per frame, sent after its final byte.
// configuration: cfg_we_i writes the maximum frame length (reset value 1518);
//   write it only while no frame is in flight.
// throughput: one byte per cycle sustained; the per-byte work is a set of
//   compares and a counter update between the input register and the
//   result register.
// verdict path: the final byte passes the input register, then the result
//   register, where the verdict item is held until it is taken.
// stall: while a verdict waits on m_axis_tready_i, non-final bytes keep
//   flowing; a further final byte holds in the input register until the
//   waiting verdict is taken.
// reset: clears all frame state and both valid flags; the length limit
//   returns to 1518.
// frame position saturates at 2^PositionBits - 1; bytes beyond are counted
//   no further.
module sip_frame_classifier #(
  parameter int unsigned PositionBits = 14
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [7:0]                    s_axis_tdata_i,   // [7:0] frame_byte
  input  logic                          s_axis_tlast_i,   // last_byte
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [2:0] verdict, [3] is_response, [9:4] sip_offset, [23:10] sip_length,
  // [37:24] frame_length, [39:38] zero
  output logic [sfc_pkg::OutDataW-1:0]  m_axis_tdata_o,
  input  logic                          cfg_we_i,
  input  logic [sfc_pkg::LenW-1:0]      cfg_wdata_i
);
  import sfc_pkg::*;

  logic            in_vld_q;
  logic [7:0]      byte_q;
  logic            last_q;
  logic [LenW-1:0] max_len_q;
  logic            out_vld_q;
  sfc_result_t     out_q;
  sfc_result_t     result;
  logic            advance;

  // a final byte needs a free result slot, other bytes always move on
  assign advance         = in_vld_q && (!last_q || !out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxLenReset;
    end else if (cfg_we_i) begin
      max_len_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      byte_q <= s_axis_tdata_i;
      last_q <= s_axis_tlast_i;
    end
  end

  sfc_frame_parser #(
    .PositionBits(PositionBits)
  ) u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .byte_i    (byte_q),
    .last_i    (last_q),
    .max_len_i (max_len_q),
    .result_o  (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance && last_q) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && last_q) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {{(OutDataW - $bits(sfc_result_t)){1'b0}}, out_q};

endmodule

>>> hw/rtl/sfc_frame_parser.sv
module sfc_frame_parser #(
  parameter int unsigned PositionBits = 14
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic [7:0]                byte_i,
  input  logic                      last_i,
  input  logic [sfc_pkg::LenW-1:0]  max_len_i,
  output sfc_pkg::sfc_result_t      result_o
);
  import sfc_pkg::*;

  localparam int unsigned PW = PositionBits;
  localparam int unsigned CW = (PW > LenW) ? PW : LenW;
  localparam logic [PW-1:0] PosMax = {PW{1'b1}};

  logic [PW-1:0] pos_q, pos_d;
  logic [15:0]   ether_q, ether_d;
  logic          ipv4_q, ipv4_d;
  kind_e         kind_q, kind_d;
  logic [31:0]   prefix_q, prefix_d;
  logic          line_end_q, line_end_d;
  logic [PW-1:0] nl_idx_q, nl_idx_d;
  logic [PW-1:0] s_idx_q, s_idx_d;
  logic          s_seen_q, s_seen_d;
  logic [1:0]    match_q, match_d;
  logic          marker_q, marker_d;

  logic [OffW-1:0] off;
  logic [PW-1:0]   pay_idx;
  logic [CW-1:0]   n_ext;
  logic [PW-1:0]   len_diff;
  logic [CW-1:0]   len_ext;
  logic            marker_ok;
  verdict_e        verdict;

  always_comb begin
    pos_d      = pos_q;
    ether_d    = ether_q;
    ipv4_d     = ipv4_q;
    kind_d     = kind_q;
    prefix_d   = prefix_q;
    line_end_d = line_end_q;
    nl_idx_d   = nl_idx_q;
    s_idx_d    = s_idx_q;
    s_seen_d   = s_seen_q;
    match_d    = match_q;
    marker_d   = marker_q;
    pay_idx    = '0;

    // bytes at the saturated count are not examined
    if (pos_q != PosMax) begin
      if (pos_q == PW'(PosEtherHi)) begin
        ether_d = {byte_i, 8'h00};
      end else if (pos_q == PW'(PosEtherLo)) begin
        ether_d = {ether_q[15:8], byte_i};
      end else if (pos_q == PW'(PosVersion)) begin
        ipv4_d = (byte_i[7:4] == 4'd4);
      end else if (pos_q == PW'(PosProtocol)) begin
        if (byte_i == ProtoTcp) begin
          kind_d = KIND_TCP;
        end else if (byte_i == ProtoUdp) begin
          kind_d = KIND_UDP;
        end else begin
          kind_d = KIND_OTHER;
        end
      end

      if (payload_off(kind_d) != '0 && pos_q >= PW'(payload_off(kind_d))) begin
        pay_idx = pos_q - PW'(payload_off(kind_d));
        if (pay_idx < PW'(PrefixLen)) begin
          unique case (pay_idx[1:0])
            2'd0: prefix_d[31:24] = byte_i;
            2'd1: prefix_d[23:16] = byte_i;
            2'd2: prefix_d[15:8]  = byte_i;
            default: prefix_d[7:0] = byte_i;
          endcase
        end
        if (!line_end_q) begin
          if (byte_i == CharNewline) begin
            line_end_d = 1'b1;
            nl_idx_d   = pay_idx;
          end else if (byte_i == CharS && pay_idx != '0) begin
            s_idx_d  = pay_idx;
            s_seen_d = 1'b1;
            match_d  = 2'd0;
            marker_d = 1'b0;
          end else if (s_seen_q && !marker_q && match_q != 2'd3) begin
            if (byte_i == ip_tail(match_q)) begin
              match_d  = match_q + 2'd1;
              marker_d = (match_q == 2'd2);
            end else begin
              match_d = 2'd3;
            end
          end
        end
      end
      pos_d = pos_q + PW'(1);
    end
  end

  // verdict from the state including the final byte
  always_comb begin
    off       = payload_off(kind_d);
    n_ext     = CW'(pos_d);
    marker_ok = line_end_d && s_seen_d && marker_d &&
                ({1'b0, s_idx_d} + (PW+1)'(MarkerGap) <= {1'b0, nl_idx_d});

    priority if (n_ext > CW'(max_len_i)) begin
      verdict = VERDICT_TOO_LONG;
    end else if (pos_d < PW'(EtherHdrLen) || ether_d != EtherTypeIpv4) begin
      verdict = VERDICT_NOT_ETHERIP;
    end else if (pos_d == PW'(EtherHdrLen)) begin
      verdict = VERDICT_NO_SIP;
    end else if (!ipv4_d) begin
      verdict = VERDICT_NOT_IPV4;
    end else if (pos_d < PW'(ProtoEnd)) begin
      verdict = VERDICT_NO_SIP;
    end else if (off == '0) begin
      verdict = VERDICT_NOT_TCP_UDP;
    end else if ({1'b0, pos_d} >= (PW+1)'(off) + (PW+1)'(PrefixLen) &&
                 (prefix_d == SipWord || marker_ok)) begin
      verdict = VERDICT_SIP;
    end else begin
      verdict = VERDICT_NO_SIP;
    end

    result_o.verdict     = verdict;
    result_o.is_response = (verdict == VERDICT_SIP) && (prefix_d == SipWord);

    len_diff = (pos_d > PW'(off)) ? pos_d - PW'(off) : '0;
    len_ext  = CW'(len_diff);
    if ((verdict == VERDICT_SIP || verdict == VERDICT_NO_SIP) && off != '0) begin
      result_o.sip_offset = off;
      result_o.sip_length = (len_ext > CW'(FieldMax)) ? FieldMax : len_ext[LenW-1:0];
    end else begin
      result_o.sip_offset = '0;
      result_o.sip_length = '0;
    end
    result_o.frame_length = (n_ext > CW'(FieldMax)) ? FieldMax : n_ext[LenW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      ether_q    <= '0;
      ipv4_q     <= 1'b0;
      kind_q     <= KIND_NONE;
      prefix_q   <= '0;
      line_end_q <= 1'b0;
      nl_idx_q   <= '0;
      s_idx_q    <= '0;
      s_seen_q   <= 1'b0;
      match_q    <= '0;
      marker_q   <= 1'b0;
    end else if (step_i) begin
      if (last_i) begin
        pos_q      <= '0;
        ether_q    <= '0;
        ipv4_q     <= 1'b0;
        kind_q     <= KIND_NONE;
        prefix_q   <= '0;
        line_end_q <= 1'b0;
        nl_idx_q   <= '0;
        s_idx_q    <= '0;
        s_seen_q   <= 1'b0;
        match_q    <= '0;
        marker_q   <= 1'b0;
      end else begin
        pos_q      <= pos_d;
        ether_q    <= ether_d;
        ipv4_q     <= ipv4_d;
        kind_q     <= kind_d;
        prefix_q   <= prefix_d;
        line_end_q <= line_end_d;
        nl_idx_q   <= nl_idx_d;
        s_idx_q    <= s_idx_d;
        s_seen_q   <= s_seen_d;
        match_q    <= match_d;
        marker_q   <= marker_d;
      end
    end
  end

endmodule

>>> bench/sfc_verdict_checker.sv
`timescale 1ns / 100ps

module sfc_verdict_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_tvalid_i,
  input  logic                         s_tready_i,
  input  logic [7:0]                   s_tdata_i,
  input  logic                         s_tlast_i,
  input  logic                         m_tvalid_i,
  input  logic                         m_tready_i,
  input  logic [sfc_pkg::OutDataW-1:0] m_tdata_i,
  input  logic                         cfg_we_i,
  input  logic [sfc_pkg::LenW-1:0]     cfg_wdata_i,
  output int                           mismatch_count_o,
  output int                           pending_count_o
);
  import sfc_pkg::*;

  localparam logic [LenW-1:0] PosSat = '1;
  localparam logic [23:0]     IpTail = "IP/";

  logic [LenW-1:0] length_limit = MaxLenReset;
  logic [LenW-1:0] byte_count   = '0;
  logic [LenW-1:0] newline_at   = '0;
  logic [LenW-1:0] last_s_at    = '0;
  logic [15:0]     ethertype    = '0;
  logic [31:0]     prefix_word  = '0;
  logic [1:0]      tail_matched = '0;
  logic            version_ok   = 1'b0;
  logic            line_done    = 1'b0;
  logic            s_found      = 1'b0;
  logic            marker_ok    = 1'b0;
  kind_e           transport    = KIND_NONE;

  sfc_result_t verdict_queue[$];
  int          mismatches = 0;

  task automatic clear_frame_state();
    byte_count   = '0;
    ethertype    = '0;
    version_ok   = 1'b0;
    transport    = KIND_NONE;
    prefix_word  = '0;
    line_done    = 1'b0;
    newline_at   = '0;
    last_s_at    = '0;
    s_found      = 1'b0;
    tail_matched = '0;
    marker_ok    = 1'b0;
  endtask

  function automatic int unsigned header_bytes(kind_e kind);
    case (kind)
      KIND_UDP: return 32'(UdpOffset);
      KIND_TCP: return 32'(TcpOffset);
      default:  return 0;
    endcase
  endfunction

  // marker search runs on the first line of the payload only
  task automatic scan_payload(int unsigned p, logic [7:0] b);
    if (p < PrefixLen) prefix_word[31-8*p -: 8] = b;
    if (line_done) return;
    if (b == CharNewline) begin
      line_done  = 1'b1;
      newline_at = LenW'(p);
      return;
    end
    if (b == CharS && p >= 1) begin
      last_s_at    = LenW'(p);
      s_found      = 1'b1;
      tail_matched = '0;
      marker_ok    = 1'b0;
      return;
    end
    if (s_found && !marker_ok && tail_matched < 3) begin
      if (b == IpTail[23-8*tail_matched -: 8]) begin
        tail_matched = tail_matched + 2'd1;
        if (tail_matched == 3) marker_ok = 1'b1;
      end else begin
        tail_matched = 2'd3;
      end
    end
  endtask

  task automatic classify_byte(logic [7:0] b, logic last);
    int unsigned idx, base, n;
    verdict_e    v;
    sfc_result_t want;
    idx = 32'(byte_count);
    if (idx < PosSat) begin
      case (idx)
        PosEtherHi:  ethertype[15:8] = b;
        PosEtherLo:  ethertype[7:0] = b;
        PosVersion:  version_ok = (b[7:4] == 4'd4);
        PosProtocol: begin
          if (b == ProtoTcp) transport = KIND_TCP;
          else if (b == ProtoUdp) transport = KIND_UDP;
          else transport = KIND_OTHER;
        end
        default: ;
      endcase
      base = header_bytes(transport);
      if (base != 0 && idx >= base) scan_payload(idx - base, b);
      byte_count = LenW'(idx + 1);
    end
    if (!last) return;

    n    = 32'(byte_count);
    base = header_bytes(transport);
    want = '0;
    if (n > length_limit) v = VERDICT_TOO_LONG;
    else if (n < EtherHdrLen || ethertype != EtherTypeIpv4) v = VERDICT_NOT_ETHERIP;
    else if (n < EtherHdrLen + 1) v = VERDICT_NO_SIP;
    else if (!version_ok) v = VERDICT_NOT_IPV4;
    else if (n < ProtoEnd) v = VERDICT_NO_SIP;
    else if (base == 0) v = VERDICT_NOT_TCP_UDP;
    else begin
      v = VERDICT_NO_SIP;
      if (n >= base + PrefixLen) begin
        if (prefix_word == SipWord) begin
          v = VERDICT_SIP;
          want.is_response = 1'b1;
        end else if (line_done && s_found && marker_ok &&
                     int'(last_s_at) + MarkerGap <= int'(newline_at)) begin
          v = VERDICT_SIP;
        end
      end
    end
    if ((v == VERDICT_SIP || v == VERDICT_NO_SIP) && base != 0) begin
      want.sip_offset = OffW'(base);
      want.sip_length = LenW'((n > base) ? n - base : 0);
    end
    want.verdict      = v;
    want.frame_length = LenW'(n);
    verdict_queue.push_back(want);
    clear_frame_state();
  endtask

  task automatic note_mismatch(string what, longint unsigned want, longint unsigned got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s: expected %0d, got %0d", what, want, got);
  endtask

  task automatic check_verdict(logic [OutDataW-1:0] data);
    sfc_result_t got, want;
    got = data[$bits(sfc_result_t)-1:0];
    if (verdict_queue.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("verdict item with none pending: %h", data);
      return;
    end
    want = verdict_queue.pop_front();
    if (got.verdict != want.verdict) note_mismatch("verdict", want.verdict, got.verdict);
    if (got.is_response != want.is_response)
      note_mismatch("is_response", want.is_response, got.is_response);
    if (got.sip_offset != want.sip_offset)
      note_mismatch("sip_offset", want.sip_offset, got.sip_offset);
    if (got.sip_length != want.sip_length)
      note_mismatch("sip_length", want.sip_length, got.sip_length);
    if (got.frame_length != want.frame_length)
      note_mismatch("frame_length", want.frame_length, got.frame_length);
    if (data[OutDataW-1:$bits(sfc_result_t)] != '0)
      note_mismatch("pad bits", 0, data[OutDataW-1:$bits(sfc_result_t)]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      length_limit = MaxLenReset;
      clear_frame_state();
      verdict_queue.delete();
    end else begin
      if (cfg_we_i) length_limit = cfg_wdata_i;
      if (s_tvalid_i && s_tready_i) classify_byte(s_tdata_i, s_tlast_i);
      if (m_tvalid_i && m_tready_i) check_verdict(m_tdata_i);
    end
    mismatch_count_o <= mismatches;
    pending_count_o  <= verdict_queue.size();
  end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import sfc_pkg::*;

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                byte_valid    = 1'b0;
  logic [7:0]          byte_data     = '0;
  logic                byte_last     = 1'b0;
  logic                verdict_ready = 1'b0;
  logic                limit_we      = 1'b0;
  logic [LenW-1:0]     limit_wdata   = '0;
  logic                byte_ready;
  logic                verdict_valid;
  logic [OutDataW-1:0] verdict_data;

  int          mismatches;
  int          pending_verdicts;
  int unsigned sender_idle_pct    = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned hold_requests      = 0;
  int unsigned holds_served       = 0;
  int unsigned bytes_sent         = 0;
  logic [7:0]  frame_buf[$];

  sip_frame_classifier uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(byte_valid),
    .s_axis_tready_o(byte_ready),
    .s_axis_tdata_i (byte_data),
    .s_axis_tlast_i (byte_last),
    .m_axis_tvalid_o(verdict_valid),
    .m_axis_tready_i(verdict_ready),
    .m_axis_tdata_o (verdict_data),
    .cfg_we_i       (limit_we),
    .cfg_wdata_i    (limit_wdata)
  );

  sfc_verdict_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_tvalid_i      (byte_valid),
    .s_tready_i      (byte_ready),
    .s_tdata_i       (byte_data),
    .s_tlast_i       (byte_last),
    .m_tvalid_i      (verdict_valid),
    .m_tready_i      (verdict_ready),
    .m_tdata_i       (verdict_data),
    .cfg_we_i        (limit_we),
    .cfg_wdata_i     (limit_wdata),
    .mismatch_count_o(mismatches),
    .pending_count_o (pending_verdicts)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

  // verdict side: random stalls, plus a long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (holds_served != hold_requests) begin
        holds_served++;
        verdict_ready <= 1'b0;
        repeat (400) @(posedge clk_i);
      end
      verdict_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(255));
  endfunction

  task automatic send_byte(logic [7:0] b, logic last);
    while ($urandom_range(99) < sender_idle_pct) begin
      byte_valid <= 1'b0;
      @(posedge clk_i);
    end
    byte_valid <= 1'b1;
    byte_data  <= b;
    byte_last  <= last;
    do @(posedge clk_i); while (!byte_ready);
    bytes_sent++;
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_buf.size(); i++) send_byte(frame_buf[i], i == frame_buf.size() - 1);
  endtask

  task automatic wait_drained();
    byte_valid <= 1'b0;
    do @(posedge clk_i); while (pending_verdicts != 0);
  endtask

  task automatic set_limit(logic [LenW-1:0] value);
    wait_drained();
    repeat (4) @(posedge clk_i);
    limit_we    <= 1'b1;
    limit_wdata <= value;
    @(posedge clk_i);
    limit_we    <= 1'b0;
  endtask

  function automatic logic [7:0] pick_char(string set);
    return set[$urandom_range(set.len() - 1)];
  endfunction

  // ethernet + ip headers, then transport header bytes up to the payload
  task automatic start_frame(logic [15:0] ethertype, logic [7:0] version, logic [7:0] proto);
    frame_buf.delete();
    repeat (12) frame_buf.push_back(rand_byte());
    frame_buf.push_back(ethertype[15:8]);
    frame_buf.push_back(ethertype[7:0]);
    frame_buf.push_back(version);
    repeat (8) frame_buf.push_back(rand_byte());
    frame_buf.push_back(proto);
    repeat ((proto == ProtoTcp) ? TcpOffset - ProtoEnd : UdpOffset - ProtoEnd)
      frame_buf.push_back(rand_byte());
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) frame_buf.push_back(s[i]);
  endtask

  task automatic trim_to(int unsigned len);
    while (frame_buf.size() > len) frame_buf.delete(frame_buf.size() - 1);
  endtask

  task automatic add_payload();
    case ($urandom_range(4))
      0: begin
        add_text("SIP/");
        repeat ($urandom_range(20))
          frame_buf.push_back(pick_char("ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789 :.@;\r\n"));
      end
      1: begin
        // request line; the gap after the marker straddles the minimum distance
        repeat ($urandom_range(6)) frame_buf.push_back(pick_char("ABCDEFGHIJKLMNOPQRSTUVWXYZ"));
        add_text(" SIP/");
        repeat ($urandom_range(6)) frame_buf.push_back(pick_char("abc019. :"));
        frame_buf.push_back(CharNewline);
        repeat ($urandom_range(8)) frame_buf.push_back(rand_byte());
      end
      2: begin
        repeat ($urandom_range(30)) begin
          if ($urandom_range(3) == 0) frame_buf.push_back(rand_byte());
          else frame_buf.push_back(pick_char("SIP/\n x"));
        end
      end
      3: repeat ($urandom_range(30)) frame_buf.push_back(rand_byte());
      default: repeat ($urandom_range(3)) frame_buf.push_back(rand_byte());
    endcase
  endtask

  task automatic make_random_frame();
    int unsigned pick;
    logic [7:0]  proto, field;
    pick  = $urandom_range(99);
    proto = $urandom_range(1) ? ProtoTcp : ProtoUdp;
    if (pick < 8) begin
      start_frame(EtherTypeIpv4, 8'h45, proto);
      add_payload();
      trim_to($urandom_range(frame_buf.size(), 1));
    end else if (pick < 14) begin
      start_frame(16'($urandom_range(16'hFFFF)), 8'h45, proto);
      add_payload();
    end else if (pick < 20) begin
      field = rand_byte();
      if (field[7:4] == 4'd4) field[7:4] = 4'd5;
      start_frame(EtherTypeIpv4, field, proto);
      add_payload();
    end else if (pick < 26) begin
      field = rand_byte();
      if (field == ProtoTcp || field == ProtoUdp) field = 8'd1;
      start_frame(EtherTypeIpv4, 8'h45, field);
      add_payload();
    end else begin
      field = {4'd4, 4'($urandom_range(15))};
      start_frame(EtherTypeIpv4, field, proto);
      add_payload();
    end
  endtask

  initial begin
    int unsigned frames, bytes_at_start;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single byte, all ones
    frame_buf.delete();
    frame_buf.push_back(8'hFF);
    send_frame();
    // all zero, one byte short of the ethernet header
    frame_buf.delete();
    repeat (13) frame_buf.push_back(8'h00);
    send_frame();
    // missing version byte
    start_frame(EtherTypeIpv4, 8'h45, ProtoUdp);
    trim_to(EtherHdrLen);
    send_frame();
    start_frame(EtherTypeIpv4, 8'h45, ProtoUdp);
    trim_to(EtherHdrLen + 1);
    send_frame();
    start_frame(EtherTypeIpv4, 8'h65, ProtoUdp);
    trim_to(EtherHdrLen + 1);
    send_frame();
    // missing protocol byte
    start_frame(EtherTypeIpv4, 8'h45, ProtoTcp);
    trim_to(20);
    send_frame();
    // protocol known but headers cut short
    start_frame(EtherTypeIpv4, 8'h45, ProtoUdp);
    trim_to(ProtoEnd);
    send_frame();
    start_frame(EtherTypeIpv4, 8'h45, ProtoUdp);
    add_text("SIP/2.0 200 OK\r\n");
    send_frame();
    start_frame(EtherTypeIpv4, 8'h4F, ProtoTcp);
    add_text("INVITE sip:a@b SIP/2.0\r\nVia: x\r\n");
    send_frame();

    set_limit('0);
    frame_buf.delete();
    frame_buf.push_back(8'h00);
    send_frame();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct = 0;  receiver_stall_pct = 0;  set_limit(MaxLenReset);
        end
        1: begin
          sender_idle_pct = 77; receiver_stall_pct = 0;  set_limit(14'd60);
        end
        2: begin
          sender_idle_pct = 0;  receiver_stall_pct = 77;
          set_limit(LenW'($urandom_range(110, 45)));
        end
        default: begin
          sender_idle_pct = 24; receiver_stall_pct = 24; set_limit(FieldMax);
        end
      endcase
      frames         = 0;
      bytes_at_start = bytes_sent;
      while (frames < 1 || bytes_sent - bytes_at_start < 40) begin
        if (phase == 0 && frames == 0) begin
          // verdict side holds off while short frames keep coming
          hold_requests++;
          repeat (12) begin
            frame_buf.delete();
            repeat ($urandom_range(3, 1)) frame_buf.push_back(rand_byte());
            send_frame();
          end
          wait_drained();
        end
        make_random_frame();
        send_frame();
        frames++;
      end
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && pending_verdicts == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
